[rtl/core/vtl_pkg.sv]
`timescale 1ns / 1ps

package vtl_pkg;

  localparam int VOL_W             = 16;
  localparam int TAPER_ENTRIES_DEF = 101;
  localparam int PADDR_W           = 3;
  localparam int PDATA_W           = 32;

  // divider shape: 33-bit dividend, 16-bit divisor, 17-bit quotient
  localparam int NUM_W = 33;
  localparam int DEN_W = 16;
  localparam int QUO_W = 17;
  localparam int FRAC_W = 16;

  localparam logic signed [VOL_W-1:0] MIN_VOLUME_RST = -16'sd16384;
  localparam logic signed [VOL_W-1:0] MAX_VOLUME_RST = 16'sd0;

  typedef enum logic {
    ACT_TO_LINEAR = 1'b0,
    ACT_TO_CURVED = 1'b1
  } action_t;

  typedef enum logic {
    REG_MIN_VOLUME = 1'b0,
    REG_MAX_VOLUME = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // host taper, Q8.8 dB, one entry per slider step; slots past the end read 0
  localparam int ROM_LEN = 101;
  localparam logic signed [VOL_W-1:0] TAPER_ROM [ROM_LEN] = '{
    -16'sd16384, -16'sd14400, -16'sd13088, -16'sd12128, -16'sd11328,
    -16'sd10688, -16'sd10144, -16'sd9632,  -16'sd9216,  -16'sd8832,
    -16'sd8480,  -16'sd8160,  -16'sd7840,  -16'sd7584,  -16'sd7296,
    -16'sd7072,  -16'sd6848,  -16'sd6624,  -16'sd6432,  -16'sd6208,
    -16'sd6048,  -16'sd5856,  -16'sd5696,  -16'sd5536,  -16'sd5376,
    -16'sd5216,  -16'sd5088,  -16'sd4928,  -16'sd4800,  -16'sd4672,
    -16'sd4544,  -16'sd4416,  -16'sd4320,  -16'sd4192,  -16'sd4096,
    -16'sd3968,  -16'sd3872,  -16'sd3776,  -16'sd3680,  -16'sd3584,
    -16'sd3488,  -16'sd3392,  -16'sd3296,  -16'sd3200,  -16'sd3136,
    -16'sd3040,  -16'sd2944,  -16'sd2880,  -16'sd2784,  -16'sd2720,
    -16'sd2624,  -16'sd2560,  -16'sd2496,  -16'sd2432,  -16'sd2336,
    -16'sd2272,  -16'sd2208,  -16'sd2144,  -16'sd2080,  -16'sd2016,
    -16'sd1952,  -16'sd1888,  -16'sd1824,  -16'sd1760,  -16'sd1696,
    -16'sd1632,  -16'sd1600,  -16'sd1536,  -16'sd1472,  -16'sd1408,
    -16'sd1376,  -16'sd1312,  -16'sd1248,  -16'sd1216,  -16'sd1152,
    -16'sd1088,  -16'sd1056,  -16'sd992,   -16'sd960,   -16'sd896,
    -16'sd864,   -16'sd800,   -16'sd768,   -16'sd704,   -16'sd672,
    -16'sd608,   -16'sd576,   -16'sd544,   -16'sd480,   -16'sd448,
    -16'sd416,   -16'sd352,   -16'sd320,   -16'sd288,   -16'sd224,
    -16'sd192,   -16'sd160,   -16'sd128,   -16'sd64,    -16'sd32,
    16'sd0
  };

  function automatic logic signed [VOL_W-1:0] taper_at(input logic [7:0] idx);
    logic signed [VOL_W-1:0] val;
    val = '0;
    if (idx < 8'(ROM_LEN)) begin
      val = TAPER_ROM[idx[6:0]];
    end
    return val;
  endfunction

endpackage

[rtl/core/vtl_ifs.sv]
`timescale 1ns / 1ps

interface vtl_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [vtl_pkg::VOL_W-1:0]    volume_in;

  modport source (output valid, action, volume_in, input ready);
  modport sink   (input valid, action, volume_in, output ready);
endinterface

interface vtl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [vtl_pkg::VOL_W-1:0]    volume_out;
  logic                                range_error;

  modport source (output valid, volume_out, range_error, input ready);
  modport sink   (input valid, volume_out, range_error, output ready);
endinterface

[rtl/core/vtl_ram.sv]
`timescale 1ns / 1ps

module vtl_ram #(
  parameter int WIDTH = vtl_pkg::VOL_W,
  parameter int DEPTH = vtl_pkg::TAPER_ENTRIES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/vtl_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Needs num < den * 2**QUO_W (upper dividend bits below the divisor).
module vtl_div (
  input  logic               clk,
  input  logic               rst,
  input  vtl_pkg::div_cmd_t  cmd,
  output vtl_pkg::div_rsp_t  rsp
);

  localparam int DW = vtl_pkg::DEN_W;
  localparam int QW = vtl_pkg::QUO_W;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [QW-1:0] sh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  assign trial = {rem, sh[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        rem  <= cmd.num[vtl_pkg::NUM_W-1:QW];
        sh   <= cmd.num[QW-1:0];
        den  <= cmd.den;
        cnt  <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[DW+1]) begin
          rem <= diff[DW-1:0];
          sh  <= {sh[QW-2:0], 1'b1};
        end else begin
          rem <= trial[DW-1:0];
          sh  <= {sh[QW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = sh;

endmodule

[rtl/core/volume_taper_linearizer_unit.sv]
`timescale 1ns / 1ps

// Volume taper linearizer. Converts a signed Q8.8 dB volume between the host
// taper curve (held in a TAPER_ENTRIES-deep taper RAM) and the linear range
// min_volume..max_volume set over the APB port (min at 0x0, max at 0x4).
// action 0 maps curved to linear, action 1 maps linear to curved. If max is
// not above min the item returns min_volume with range_error set.
// After reset the taper RAM is loaded from the built-in table, one entry a
// cycle, so req.ready stays low until every entry has been written.
// One item is worked at a time. The taper RAM has one registered read port,
// so each binary-search step issues its read in S_F_LOOP and compares in
// S_F_CMP. The two divisions by a variable (segment span, volume range)
// share one serial divider of 17 steps. The division by the step count is
// a reciprocal multiply. Curved to linear runs the search and one divide,
// and skips both when the input lies outside the taper span; linear to
// curved runs one divide and skips it when the fraction clamps; an empty
// range goes straight to the output. req.ready rises on the same edge that
// raises rsp.valid. A finished result sits in the output register while the
// next item is accepted; the next one stalls only if it finishes while that
// result is still unread.
module volume_taper_linearizer_unit #(
  parameter int TAPER_ENTRIES = vtl_pkg::TAPER_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vtl_pkg::PADDR_W-1:0]   paddr,
  input  logic [vtl_pkg::PDATA_W-1:0]   pwdata,
  output logic [vtl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  vtl_req_if.sink                       req,
  vtl_rsp_if.source                     rsp
);

  localparam int VW    = vtl_pkg::VOL_W;
  localparam int FW    = vtl_pkg::FRAC_W;
  localparam int QW    = vtl_pkg::QUO_W;
  localparam int NW    = vtl_pkg::NUM_W;
  localparam int STEPS = TAPER_ENTRIES - 1;
  localparam int AW    = $clog2(TAPER_ENTRIES);
  localparam int PW    = FW + AW;
  localparam int PRW   = 2 * PW + 1;
  localparam int RSH   = PW + $clog2(STEPS);

  localparam logic [AW-1:0]  LAST       = AW'(STEPS);
  localparam logic [PW-1:0]  HALF_STEPS = PW'(STEPS / 2);
  localparam logic [QW-1:0]  FRAC_ONE   = QW'(65536);
  // ceil(2**RSH / STEPS): exact quotient for every dividend below 2**PW
  localparam logic [PW:0]    RECIP      =
    (PW+1)'(((64'd1 << RSH) + 64'(STEPS - 1)) / 64'(STEPS));

  typedef enum logic [4:0] {
    S_FILL, S_IDLE, S_CHECK,
    S_F_FIRST, S_F_LAST, S_F_LOOP, S_F_CMP, S_F_DIV1, S_F_POS, S_F_DIV2,
    S_F_MUL, S_F_FIN,
    S_R_PREP, S_R_DIV, S_R_POS, S_R_A, S_R_B, S_R_C, S_R_MUL, S_R_FIN,
    S_OUT
  } state_t;

  // ---------------- configuration registers ----------------
  logic signed [VW-1:0] min_volume;
  logic signed [VW-1:0] max_volume;
  logic                 cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_volume <= vtl_pkg::MIN_VOLUME_RST;
      max_volume <= vtl_pkg::MAX_VOLUME_RST;
    end else if (cfg_we) begin
      case (vtl_pkg::reg_idx_t'(paddr[2]))
        vtl_pkg::REG_MIN_VOLUME: min_volume <= pwdata[VW-1:0];
        vtl_pkg::REG_MAX_VOLUME: max_volume <= pwdata[VW-1:0];
        default:                 min_volume <= min_volume;
      endcase
    end
  end

  always_comb begin
    case (vtl_pkg::reg_idx_t'(paddr[2]))
      vtl_pkg::REG_MIN_VOLUME:
        prdata = {{(vtl_pkg::PDATA_W-VW){min_volume[VW-1]}}, min_volume};
      vtl_pkg::REG_MAX_VOLUME:
        prdata = {{(vtl_pkg::PDATA_W-VW){max_volume[VW-1]}}, max_volume};
      default:
        prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_t               state;
  logic [AW-1:0]        fill_addr;
  logic                 action_q;
  logic signed [VW-1:0] vin;
  logic signed [VW:0]   range_q;      // max - min, 17 bits
  logic [AW-1:0]        lo;
  logic [AW-1:0]        hi;
  logic signed [VW-1:0] lo_val;
  logic signed [VW-1:0] hi_val;
  logic [QW-1:0]        frac;         // Q16 slider fraction, 0..65536
  logic signed [33:0]   num_r;        // reverse dividend, may be negative
  logic                 full;         // reverse fraction clamped to one
  logic [AW-1:0]        idx;
  logic [FW-1:0]        rem;
  logic signed [VW-1:0] a_val;
  logic signed [VW:0]   delta;
  logic [32:0]          fprod;
  logic [PRW-1:0]       qprod;        // position times reciprocal of steps
  logic signed [33:0]   rprod;
  logic signed [VW-1:0] res_q;
  logic                 err_q;
  logic                 rsp_valid;
  logic signed [VW-1:0] out_vol;
  logic                 out_err;

  // ---------------- taper RAM ----------------
  logic [AW-1:0]        rd_addr;
  logic [VW-1:0]        rdata;
  logic signed [VW-1:0] rom_q;
  logic                 fill_we;
  logic [VW-1:0]        fill_data;

  assign fill_we   = (state == S_FILL);
  assign fill_data = vtl_pkg::taper_at(8'(fill_addr));
  assign rom_q     = $signed(rdata);

  vtl_ram #(.WIDTH(VW), .DEPTH(TAPER_ENTRIES)) u_taper (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // binary search midpoint
  logic [AW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic          more_steps;

  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[AW:1];
  assign more_steps = (hi - lo) > AW'(1);

  // read address: data shows up in the following state
  always_comb begin
    case (state)
      S_CHECK:   rd_addr = '0;
      S_F_FIRST: rd_addr = LAST;
      S_F_LOOP:  rd_addr = mid;
      S_R_A:     rd_addr = idx;
      S_R_B:     rd_addr = idx + AW'(1);
      default:   rd_addr = '0;
    endcase
  end

  // ---------------- shared divider ----------------
  vtl_pkg::div_cmd_t div_cmd;
  vtl_pkg::div_rsp_t div_rsp;

  logic signed [VW:0]   span;
  logic signed [VW:0]   seg_off;
  logic [NW-1:0]        fwd_num1;
  logic [PW-1:0]        fwd_num2;
  logic                 rev_neg;
  logic                 rev_full;

  assign span     = {hi_val[VW-1], hi_val} - {lo_val[VW-1], lo_val};
  assign seg_off  = {vin[VW-1], vin} - {lo_val[VW-1], lo_val};
  // (v - rom[lo]) * 65536 + span / 2
  assign fwd_num1 = NW'({seg_off[VW-1:0], 16'h0000}) + NW'(span[VW-1:1]);
  // lo * 65536 + fin + steps / 2
  assign fwd_num2 = (PW'(lo) << 16) + PW'(frac) + HALF_STEPS;
  assign rev_neg  = num_r[33];
  assign rev_full = num_r[32:0] >= {1'b0, range_q[VW-1:0], 16'h0000};

  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.num   = fwd_num1;
    div_cmd.den   = span[VW-1:0];
    case (state)
      S_F_LOOP: begin
        div_cmd.start = !more_steps;
      end
      S_R_PREP: begin
        div_cmd.start = !rev_neg && !rev_full;
        div_cmd.num   = num_r[NW-1:0];
        div_cmd.den   = range_q[VW-1:0];
      end
      default: begin
        div_cmd.start = 1'b0;
      end
    endcase
  end

  vtl_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  // ---------------- datapath helpers ----------------
  logic signed [VW:0]   vin_off;
  logic [PW-1:0]        pos;
  logic [32:0]          fsum;
  logic signed [33:0]   rsum;
  logic signed [33:0]   rfloor;
  logic [VW-1:0]        rstep;

  assign vin_off = {vin[VW-1], vin} - {min_volume[VW-1], min_volume};
  assign pos     = PW'(frac[FW-1:0]) * PW'(STEPS);
  assign fsum    = fprod + 33'd32768;
  assign rsum    = rprod + 34'sd32768;
  assign rfloor  = rsum >>> 16;
  // round toward zero: floor plus one for a negative value with a remainder
  assign rstep   = rfloor[VW-1:0] + VW'(rsum[33] && (rsum[15:0] != 16'h0000));

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fill_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (rsp.ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            action_q <= req.action;
            vin      <= req.volume_in;
            range_q  <= {max_volume[VW-1], max_volume} - {min_volume[VW-1], min_volume};
            state    <= S_CHECK;
          end
        end

        S_CHECK: begin
          num_r <= $signed({vin_off[VW], vin_off, 16'h0000})
                 + $signed({19'h0, range_q[VW-1:1]});
          if (range_q[VW] || (range_q == '0)) begin
            res_q <= min_volume;
            err_q <= 1'b1;
            state <= S_OUT;
          end else if (action_q == vtl_pkg::ACT_TO_CURVED) begin
            err_q <= 1'b0;
            state <= S_R_PREP;
          end else begin
            err_q <= 1'b0;
            state <= S_F_FIRST;
          end
        end

        // ---- curved to linear ----
        S_F_FIRST: begin
          lo_val <= rom_q;
          if (vin <= rom_q) begin
            frac  <= '0;
            state <= S_F_MUL;
          end else begin
            state <= S_F_LAST;
          end
        end

        S_F_LAST: begin
          hi_val <= rom_q;
          lo     <= '0;
          hi     <= LAST;
          if (vin >= rom_q) begin
            frac  <= FRAC_ONE;
            state <= S_F_MUL;
          end else begin
            state <= S_F_LOOP;
          end
        end

        S_F_LOOP: begin
          state <= more_steps ? S_F_CMP : S_F_DIV1;
        end

        S_F_CMP: begin
          if (rom_q <= vin) begin
            lo     <= mid;
            lo_val <= rom_q;
          end else begin
            hi     <= mid;
            hi_val <= rom_q;
          end
          state <= S_F_LOOP;
        end

        S_F_DIV1: begin
          if (div_rsp.done) begin
            frac  <= div_rsp.quo;
            state <= S_F_POS;
          end
        end

        // divide by the step count: 23 x 24 bit multiply at 101 entries
        S_F_POS: begin
          qprod <= PRW'(fwd_num2) * PRW'(RECIP);
          state <= S_F_DIV2;
        end

        S_F_DIV2: begin
          frac  <= qprod[RSH +: QW];
          state <= S_F_MUL;
        end

        S_F_MUL: begin
          fprod <= 33'(range_q[VW-1:0]) * 33'(frac);
          state <= S_F_FIN;
        end

        S_F_FIN: begin
          res_q <= min_volume + $signed(fsum[VW+15:16]);
          state <= S_OUT;
        end

        // ---- linear to curved ----
        S_R_PREP: begin
          if (rev_neg) begin
            full  <= 1'b0;
            idx   <= '0;
            rem   <= '0;
            state <= S_R_A;
          end else if (rev_full) begin
            full  <= 1'b1;
            idx   <= LAST - AW'(1);
            rem   <= '0;
            state <= S_R_A;
          end else begin
            full  <= 1'b0;
            state <= S_R_DIV;
          end
        end

        S_R_DIV: begin
          if (div_rsp.done) begin
            frac  <= div_rsp.quo;
            state <= S_R_POS;
          end
        end

        S_R_POS: begin
          idx   <= pos[PW-1:FW];
          rem   <= pos[FW-1:0];
          state <= S_R_A;
        end

        S_R_A: begin
          state <= S_R_B;
        end

        S_R_B: begin
          a_val <= rom_q;
          state <= S_R_C;
        end

        S_R_C: begin
          delta <= {rom_q[VW-1], rom_q} - {a_val[VW-1], a_val};
          if (full) begin
            res_q <= rom_q;
            state <= S_OUT;
          end else begin
            state <= S_R_MUL;
          end
        end

        S_R_MUL: begin
          rprod <= $signed(delta) * $signed({1'b0, rem});
          state <= S_R_FIN;
        end

        S_R_FIN: begin
          res_q <= a_val + $signed(rstep);
          state <= S_OUT;
        end

        // hand over to the output register once it is free
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            out_vol   <= res_q;
            out_err   <= err_q;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.volume_out  = out_vol;
  assign rsp.range_error = out_err;

endmodule

[rtl/core/vtl_checker.sv]
`timescale 1ns / 1ps

module vtl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [vtl_pkg::VOL_W-1:0]   volume_out,
  input logic                        range_error
);

  logic       req_acc;
  logic       rsp_acc;
  logic [1:0] pend;   // items taken in but not yet delivered

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(req_acc) - 2'(rsp_acc);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(volume_out) && $stable(range_error))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 2'd0)
    else $error("result without a pending item");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_acc |-> pend != 2'd2)
    else $error("item taken while another is in work and one waits");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_acc |=> !req_ready)
    else $error("ready right after an item was taken");

endmodule

bind volume_taper_linearizer_unit vtl_checker u_vtl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .volume_out  (rsp.volume_out),
  .range_error (rsp.range_error)
);

[dv/taper_checker.sv]
`timescale 1ns / 1ps

// Watches the register port and both channels. Keeps its own copy of the
// volume range and a queue of predicted results.
module taper_checker
  import vtl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  vtl_req_if                 req,
  vtl_rsp_if                 rsp,
  output int                 fail_count,
  output int                 pending
);

  localparam int     STEPS = TAPER_ENTRIES_DEF - 1;
  localparam longint ONE   = 65536;   // 1.0 in Q16

  typedef struct packed {
    logic signed [VOL_W-1:0] volume;
    logic                    range_error;
  } volume_result_t;

  longint         min_level;
  longint         max_level;
  volume_result_t expected_volumes[$];
  int             errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint taper_level(longint idx);
    return longint'(TAPER_ROM[int'(idx)]);
  endfunction

  // curved level -> slider fraction in Q16
  function automatic longint level_to_fraction(longint v);
    longint lo, hi, mid, span, fin;
    if (v <= taper_level(0)) return 0;
    if (v >= taper_level(STEPS)) return ONE;
    lo = 0;
    hi = STEPS;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (taper_level(mid) <= v) lo = mid;
      else hi = mid;
    end
    span = taper_level(hi) - taper_level(lo);
    fin  = 0;
    if (span > 0) fin = ((v - taper_level(lo)) * ONE + span / 2) / span;
    return (lo * ONE + fin + STEPS / 2) / STEPS;
  endfunction

  // slider fraction in Q16 -> curved level
  function automatic longint fraction_to_level(longint frac);
    longint pos, idx, rem, a, b;
    if (frac <= 0) return taper_level(0);
    if (frac >= ONE) return taper_level(STEPS);
    pos = frac * STEPS;
    idx = pos / ONE;
    rem = pos % ONE;
    a   = taper_level(idx);
    b   = taper_level(idx + 1);
    return a + ((b - a) * rem + ONE / 2) / ONE;
  endfunction

  function automatic volume_result_t convert_volume(action_t act,
                                                    logic signed [VOL_W-1:0] vin);
    longint         span, lin, frac, res;
    volume_result_t r;
    span          = max_level - min_level;
    lin           = longint'(vin);
    r.range_error = 1'b0;
    if (span <= 0) begin
      res           = min_level;
      r.range_error = 1'b1;
    end else if (act == ACT_TO_LINEAR) begin
      res = min_level + (span * level_to_fraction(lin) + ONE / 2) / ONE;
    end else begin
      frac = ((lin - min_level) * ONE + span / 2) / span;
      res  = fraction_to_level(frac);
    end
    r.volume = res[VOL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    volume_result_t want;
    if (rst) begin
      min_level = longint'(MIN_VOLUME_RST);
      max_level = longint'(MAX_VOLUME_RST);
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_MIN_VOLUME: min_level = longint'($signed(pwdata[VOL_W-1:0]));
          REG_MAX_VOLUME: max_level = longint'($signed(pwdata[VOL_W-1:0]));
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        expected_volumes.push_back(convert_volume(action_t'(req.action), req.volume_in));
      if (rsp.valid && rsp.ready) begin
        if (expected_volumes.size() == 0) begin
          $error("volume item with nothing predicted: volume_out %0d range_error %0b",
                 rsp.volume_out, rsp.range_error);
          errors++;
        end else begin
          want = expected_volumes.pop_front();
          if (rsp.volume_out !== want.volume) begin
            $error("volume_out: expected %0d, actual %0d", want.volume, rsp.volume_out);
            errors++;
          end
          if (rsp.range_error !== want.range_error) begin
            $error("range_error: expected %0b, actual %0b",
                   want.range_error, rsp.range_error);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_volumes.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the volume taper linearizer. Checking lives in
// taper_checker, which sits beside the unit and watches the same wires.
module testbench;
  import vtl_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  vtl_req_if req_ch ();
  vtl_rsp_if rsp_ch ();

  int fail_count;
  int pending;

  // sender: percent of items preceded by a hold-off; receiver: percent of cycles held off
  int src_idle_pct = 29;
  int snk_idle_pct = 78;

  // range as last written, used only to aim the random levels
  int cur_min = -16384;
  int cur_max = 0;

  volume_taper_linearizer_unit uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  taper_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, set far beyond a clean run even at the worst stall mix.
  initial begin
    #(64'd10_000_000);
    $display("FAIL");
    $finish;
  end

  // Result side: ready toggles at random per cycle at the current rate.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic int clip16(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // Present one item and hold it until accepted. Valid stays high across
  // back-to-back items; a hold-off drops it for a gap first. Mostly short
  // gaps, now and then a long one so gaps land mid-computation too.
  task automatic issue_volume(input action_t act, input int level);
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 4))
        @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.volume_in <= 16'(clip16(level));
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted item has come back. The first
  // edge lets the checker count the item just accepted.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; psel drops before the task returns
  // so the next setup never lands in the same step as this deassert.
  task automatic write_register(input reg_idx_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the unit drained.
  task automatic set_range(input int lo, input int hi);
    wait_idle();
    write_register(REG_MIN_VOLUME, lo);
    write_register(REG_MAX_VOLUME, hi);
    cur_min = lo;
    cur_max = hi;
  endtask

  // Level aimed at where the action does interesting work. Curved input:
  // mostly inside the taper span or within two of a taper entry. Linear input:
  // mostly inside the range with a margin either side to hit the clamps.
  // The rest is any 16-bit value so every bit toggles.
  function automatic int random_level(action_t act);
    int pick;
    int span;
    pick = $urandom_range(99);
    span = cur_max - cur_min;
    if (pick >= 85) return int'($urandom_range(65535)) - 32768;
    if (act == ACT_TO_LINEAR) begin
      if (pick < 70) return int'($urandom_range(17000)) - 16700;
      return int'(TAPER_ROM[$urandom_range(TAPER_ENTRIES_DEF - 1)]) +
             int'($urandom_range(4)) - 2;
    end
    if (span <= 0) return int'($urandom_range(65535)) - 32768;
    if (pick < 75)
      return cur_min - span / 8 + int'($urandom_range(span + span / 4));
    case ($urandom_range(2))
      0: return cur_min;
      1: return cur_max;
      default: return cur_min + span / 2;
    endcase
  endfunction

  initial begin
    int     lo, hi, tmp;
    action_t act;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_TO_LINEAR;
    req_ch.volume_in = '0;
    rsp_ch.ready     = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, reset range -16384..0 ----
    // Curved to linear: full-scale extremes, both taper ends and one step
    // inside them, an exact taper entry and one just below it, mid-taper.
    issue_volume(ACT_TO_LINEAR, -32768);
    issue_volume(ACT_TO_LINEAR, 32767);
    issue_volume(ACT_TO_LINEAR, -16384);
    issue_volume(ACT_TO_LINEAR, -16383);
    issue_volume(ACT_TO_LINEAR, 0);
    issue_volume(ACT_TO_LINEAR, -1);
    issue_volume(ACT_TO_LINEAR, -14400);
    issue_volume(ACT_TO_LINEAR, -14401);
    issue_volume(ACT_TO_LINEAR, -5000);
    // Linear to curved: fraction clamps below and above, range ends, middle.
    issue_volume(ACT_TO_CURVED, -32768);
    issue_volume(ACT_TO_CURVED, 32767);
    issue_volume(ACT_TO_CURVED, -16384);
    issue_volume(ACT_TO_CURVED, 0);
    issue_volume(ACT_TO_CURVED, -8192);
    issue_volume(ACT_TO_CURVED, -16385);

    // empty range: min returned, error set, both actions
    set_range(0, 0);
    issue_volume(ACT_TO_LINEAR, 1000);
    issue_volume(ACT_TO_CURVED, -5);
    // inverted range at the register extremes
    set_range(32767, -32768);
    issue_volume(ACT_TO_LINEAR, -32768);
    issue_volume(ACT_TO_CURVED, 32767);
    // widest legal range
    set_range(-32768, 32767);
    issue_volume(ACT_TO_LINEAR, -8000);
    issue_volume(ACT_TO_CURVED, -32768);
    issue_volume(ACT_TO_CURVED, 32767);
    // narrowest legal range
    set_range(100, 101);
    issue_volume(ACT_TO_CURVED, 100);
    issue_volume(ACT_TO_CURVED, 101);

    // ---- random: nine blocks of 100, range changes between blocks ----
    // Blocks 0-2 slow receiver, 3-5 slow sender, 6-8 full rate.
    for (int seg = 0; seg < 9; seg++) begin
      lo = int'($urandom_range(65535)) - 32768;
      hi = int'($urandom_range(65535)) - 32768;
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      if (lo == hi) hi = lo + 1;
      case (seg)
        0: set_range(-16384, 0);
        1: set_range(-32768, 32767);
        3: set_range(-16384, -16383);
        5: begin
          // bad ranges mixed in: inverted half the time, sometimes empty
          if ($urandom_range(1) == 1) set_range(hi, lo);
          else if ($urandom_range(2) == 0) set_range(lo, lo);
          else set_range(lo, hi);
        end
        6: set_range(0, 32767);
        8: set_range(-24000, 6000);
        default: set_range(lo, hi);
      endcase
      src_idle_pct = (seg < 3) ? 29 : (seg < 6) ? 78 : 0;
      snk_idle_pct = (seg < 3) ? 78 : (seg < 6) ? 29 : 0;
      repeat (100) begin
        act = action_t'($urandom_range(1));
        issue_volume(act, random_level(act));
      end
    end

    wait_idle();
    // allow a margin for strays after the last item
    repeat (80) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/vtl_pkg.sv
rtl/core/vtl_ifs.sv
rtl/core/vtl_ram.sv
rtl/core/vtl_div.sv
rtl/core/volume_taper_linearizer_unit.sv
rtl/core/vtl_checker.sv
dv/taper_checker.sv
dv/testbench.sv
